// File: rtl/hcfrc_pkg.sv
// ----------------------------------------------------------------------------
// hcfrc_pkg
// Shared constants and types of the chained result cache.
// ----------------------------------------------------------------------------
package hcfrc_pkg;

	localparam int NUM_ENTRIES = 512;
	localparam int NUM_BINS    = 512;
	localparam int IDX_W       = $clog2(NUM_ENTRIES);
	localparam int LINK_W      = IDX_W + 1;
	localparam int BIN_W       = 9;
	localparam int KEY_W       = 64;
	localparam int VAL_W       = 16;
	localparam int KIND_W      = 2;

	localparam logic [LINK_W-1:0] LINK_NIL = '1;

	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_RSVD   = 2'd3;

	typedef enum logic [4:0] {
		S_IDLE, S_SWEEP, S_DEC, S_ZERO,
		S_LK_HEAD, S_LK_LOAD, S_LK_WALK, S_LK_CMP,
		S_HIT_RM, S_HIT_RDH, S_HIT_PUSH, S_HIT_FIX,
		S_TK_RD, S_TK_RM, S_TK_RDH, S_TK_PUSH, S_TK_FIX
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_SWEEP, OP_DEC, OP_ZERO,
		OP_LK_HEAD, OP_LK_LOAD, OP_LK_WALK, OP_LK_CMP,
		OP_HIT_RM, OP_HIT_RDH, OP_HIT_PUSH, OP_HIT_FIX,
		OP_TK_RD, OP_TK_RM, OP_TK_RDH, OP_TK_PUSH, OP_TK_FIX
	} op_t;

	typedef struct packed {
		logic load;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              bin_ok;
		logic              walk_end;
		logic              key_match;
		logic              sweep_last;
	} status_t;

endpackage

// File: rtl/hcfrc_ctrl.sv
// ----------------------------------------------------------------------------
// hcfrc_ctrl
// Sequencer that steps the datapath through clear sweeps, chain walks and relinks.
// ----------------------------------------------------------------------------
module hcfrc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  hcfrc_pkg::status_t status,
	output hcfrc_pkg::cmd_t    cmd,
	output logic               busy
);
	import hcfrc_pkg::*;

	state_t state_q, state_d;
	logic   rst_sweep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			rst_sweep_q <= 1'b1;
		end else begin
			state_q <= state_d;
			if (state_q == S_SWEEP && status.sweep_last) begin
				rst_sweep_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_DEC;
			end
			S_SWEEP: begin
				if (status.sweep_last) state_d = rst_sweep_q ? S_IDLE : S_ZERO;
			end
			S_DEC: begin
				if (status.kind == KIND_CLEAR) state_d = S_SWEEP;
				else if (!status.bin_ok) state_d = S_ZERO;
				else if (status.kind == KIND_LOOKUP) state_d = S_LK_HEAD;
				else if (status.kind == KIND_INSERT) state_d = S_TK_RD;
				else state_d = S_ZERO;
			end
			S_ZERO:     state_d = S_IDLE;
			S_LK_HEAD:  state_d = S_LK_LOAD;
			S_LK_LOAD:  state_d = S_LK_WALK;
			S_LK_WALK:  state_d = status.walk_end ? S_ZERO : S_LK_CMP;
			S_LK_CMP:   state_d = status.key_match ? S_HIT_RM : S_LK_WALK;
			S_HIT_RM:   state_d = S_HIT_RDH;
			S_HIT_RDH:  state_d = S_HIT_PUSH;
			S_HIT_PUSH: state_d = S_HIT_FIX;
			S_HIT_FIX:  state_d = S_TK_RD;
			S_TK_RD:    state_d = S_TK_RM;
			S_TK_RM:    state_d = S_TK_RDH;
			S_TK_RDH:   state_d = S_TK_PUSH;
			S_TK_PUSH:  state_d = S_TK_FIX;
			S_TK_FIX:   state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.load = (state_q == S_IDLE) && start;
		busy     = (state_q != S_IDLE);
		case (state_q)
			S_SWEEP:    cmd.op = OP_SWEEP;
			S_DEC:      cmd.op = OP_DEC;
			S_ZERO:     cmd.op = OP_ZERO;
			S_LK_HEAD:  cmd.op = OP_LK_HEAD;
			S_LK_LOAD:  cmd.op = OP_LK_LOAD;
			S_LK_WALK:  cmd.op = OP_LK_WALK;
			S_LK_CMP:   cmd.op = OP_LK_CMP;
			S_HIT_RM:   cmd.op = OP_HIT_RM;
			S_HIT_RDH:  cmd.op = OP_HIT_RDH;
			S_HIT_PUSH: cmd.op = OP_HIT_PUSH;
			S_HIT_FIX:  cmd.op = OP_HIT_FIX;
			S_TK_RD:    cmd.op = OP_TK_RD;
			S_TK_RM:    cmd.op = OP_TK_RM;
			S_TK_RDH:   cmd.op = OP_TK_RDH;
			S_TK_PUSH:  cmd.op = OP_TK_PUSH;
			S_TK_FIX:   cmd.op = OP_TK_FIX;
			default:    cmd.op = OP_NONE;
		endcase
	end

endmodule

// File: rtl/hcfrc_dpath.sv
// ----------------------------------------------------------------------------
// hcfrc_dpath
// Entry, link and bin head memories with the working registers.
// ----------------------------------------------------------------------------
module hcfrc_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  hcfrc_pkg::cmd_t                   cmd,
	output hcfrc_pkg::status_t                status,
	input  logic [hcfrc_pkg::KIND_W-1:0]      kind,
	input  logic [hcfrc_pkg::BIN_W-1:0]       bin_index,
	input  logic [hcfrc_pkg::KEY_W-1:0]       search_key,
	input  logic [hcfrc_pkg::VAL_W-1:0]       new_reach,
	input  logic [hcfrc_pkg::VAL_W-1:0]       new_time,
	output logic                              done,
	output logic                              hit,
	output logic [hcfrc_pkg::VAL_W-1:0]       found_reach,
	output logic [hcfrc_pkg::VAL_W-1:0]       found_time,
	output logic [hcfrc_pkg::BIN_W-1:0]       slot_used
);
	import hcfrc_pkg::*;

	logic [KEY_W-1:0]  mem_key   [NUM_ENTRIES];
	logic [BIN_W-1:0]  mem_bin   [NUM_ENTRIES];
	logic [VAL_W-1:0]  mem_reach [NUM_ENTRIES];
	logic [VAL_W-1:0]  mem_time  [NUM_ENTRIES];
	logic [LINK_W-1:0] mem_next  [NUM_ENTRIES];
	logic [LINK_W-1:0] mem_prev  [NUM_ENTRIES];
	logic [LINK_W-1:0] mem_head  [NUM_BINS];

	logic [KEY_W-1:0]  rd_key_q;
	logic [BIN_W-1:0]  rd_bin_q;
	logic [VAL_W-1:0]  rd_reach_q, rd_time_q;
	logic [LINK_W-1:0] rd_next_q, rd_prev_q, rd_head_q;

	logic [KIND_W-1:0] kind_q;
	logic [BIN_W-1:0]  bin_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  r_q, t_q;
	logic [LINK_W-1:0] cur_q, h_q;
	logic [IDX_W:0]    steps_q;
	logic [IDX_W-1:0]  sw_q, cursor_q;

	logic [IDX_W-1:0]  ent_ra, cur_idx;
	logic [BIN_W-1:0]  head_ra;

	logic              ent_we, nx_we, pv_we, hd_we;
	logic [IDX_W-1:0]  ent_wa, nx_wa, pv_wa;
	logic [BIN_W-1:0]  hd_wa;
	logic [KEY_W-1:0]  key_wd;
	logic [BIN_W-1:0]  bin_wd;
	logic [VAL_W-1:0]  reach_wd, time_wd;
	logic [LINK_W-1:0] nx_wd, pv_wd, hd_wd;

	assign cur_idx = cur_q[IDX_W-1:0];

	always_comb begin
		ent_ra   = cur_idx;
		head_ra  = bin_q;
		ent_we   = 1'b0;
		ent_wa   = cur_idx;
		key_wd   = '0;
		bin_wd   = '0;
		reach_wd = '0;
		time_wd  = '0;
		nx_we    = 1'b0;
		nx_wa    = cur_idx;
		nx_wd    = LINK_NIL;
		pv_we    = 1'b0;
		pv_wa    = cur_idx;
		pv_wd    = LINK_NIL;
		hd_we    = 1'b0;
		hd_wa    = bin_q;
		hd_wd    = LINK_NIL;
		case (cmd.op)
			OP_SWEEP: begin
				ent_we = 1'b1;
				ent_wa = sw_q;
				nx_we  = 1'b1;
				nx_wa  = sw_q;
				nx_wd  = (sw_q == IDX_W'(NUM_ENTRIES - 1)) ? LINK_NIL
					: {1'b0, sw_q} + LINK_W'(1);
				pv_we  = 1'b1;
				pv_wa  = sw_q;
				pv_wd  = (sw_q == '0) ? LINK_NIL : {1'b0, sw_q} - LINK_W'(1);
				hd_we  = 1'b1;
				hd_wa  = BIN_W'(sw_q);
				hd_wd  = (sw_q == '0) ? '0 : LINK_NIL;
			end
			OP_LK_HEAD: head_ra = bin_q;
			OP_TK_RD:   ent_ra  = cursor_q;
			OP_HIT_RM, OP_TK_RM: begin
				if (!rd_prev_q[IDX_W]) begin
					nx_we = 1'b1;
					nx_wa = rd_prev_q[IDX_W-1:0];
					nx_wd = rd_next_q;
				end else begin
					hd_we = 1'b1;
					hd_wa = rd_bin_q;
					hd_wd = rd_next_q;
				end
				if (!rd_next_q[IDX_W]) begin
					pv_we = 1'b1;
					pv_wa = rd_next_q[IDX_W-1:0];
					pv_wd = rd_prev_q;
				end
				ent_we = 1'b1;
				if (cmd.op == OP_TK_RM) begin
					key_wd   = key_q;
					bin_wd   = bin_q;
					reach_wd = r_q;
					time_wd  = t_q;
				end
			end
			OP_HIT_RDH: head_ra = '0;
			OP_HIT_PUSH, OP_TK_PUSH: begin
				nx_we = 1'b1;
				nx_wd = rd_head_q;
				pv_we = 1'b1;
				pv_wd = LINK_NIL;
				hd_we = 1'b1;
				hd_wa = (cmd.op == OP_HIT_PUSH) ? '0 : bin_q;
				hd_wd = cur_q;
			end
			OP_HIT_FIX, OP_TK_FIX: begin
				pv_we = !h_q[IDX_W];
				pv_wa = h_q[IDX_W-1:0];
				pv_wd = cur_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			mem_key[ent_wa]   <= key_wd;
			mem_bin[ent_wa]   <= bin_wd;
			mem_reach[ent_wa] <= reach_wd;
			mem_time[ent_wa]  <= time_wd;
		end
		rd_key_q   <= mem_key[ent_ra];
		rd_bin_q   <= mem_bin[ent_ra];
		rd_reach_q <= mem_reach[ent_ra];
		rd_time_q  <= mem_time[ent_ra];
	end

	always_ff @(posedge clk) begin
		if (nx_we) mem_next[nx_wa] <= nx_wd;
		rd_next_q <= mem_next[ent_ra];
	end

	always_ff @(posedge clk) begin
		if (pv_we) mem_prev[pv_wa] <= pv_wd;
		rd_prev_q <= mem_prev[ent_ra];
	end

	always_ff @(posedge clk) begin
		if (hd_we) mem_head[hd_wa] <= hd_wd;
		rd_head_q <= mem_head[head_ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			bin_q  <= bin_index;
			key_q  <= search_key;
			r_q    <= new_reach;
			t_q    <= new_time;
		end
		case (cmd.op)
			OP_LK_LOAD: begin
				cur_q   <= rd_head_q;
				steps_q <= '0;
			end
			OP_LK_WALK: steps_q <= steps_q + (IDX_W+1)'(1);
			OP_LK_CMP: begin
				if (rd_key_q == key_q) begin
					r_q <= rd_reach_q;
					t_q <= rd_time_q;
				end else begin
					cur_q <= rd_next_q;
				end
			end
			OP_TK_RD: cur_q <= {1'b0, cursor_q};
			OP_HIT_PUSH, OP_TK_PUSH: h_q <= rd_head_q;
			default: begin
			end
		endcase
		if (cmd.op == OP_TK_FIX) begin
			hit         <= (kind_q == KIND_LOOKUP);
			found_reach <= (kind_q == KIND_LOOKUP) ? r_q : '0;
			found_time  <= (kind_q == KIND_LOOKUP) ? t_q : '0;
			slot_used   <= BIN_W'(cur_idx);
		end else if (cmd.op == OP_ZERO) begin
			hit         <= 1'b0;
			found_reach <= '0;
			found_time  <= '0;
			slot_used   <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q     <= '0;
			cursor_q <= '0;
			done     <= 1'b0;
		end else begin
			done <= (cmd.op == OP_TK_FIX) || (cmd.op == OP_ZERO);
			if (cmd.op == OP_DEC) sw_q <= '0;
			if (cmd.op == OP_SWEEP) begin
				sw_q     <= sw_q + IDX_W'(1);
				cursor_q <= '0;
			end
			if (cmd.op == OP_TK_FIX) cursor_q <= cursor_q + IDX_W'(1);
		end
	end

	always_comb begin
		status.kind       = kind_q;
		status.bin_ok     = ({1'b0, bin_q} < (BIN_W+1)'(NUM_BINS));
		status.walk_end   = cur_q[IDX_W] || (steps_q == (IDX_W+1)'(NUM_ENTRIES));
		status.key_match  = (rd_key_q == key_q);
		status.sweep_last = (sw_q == IDX_W'(NUM_ENTRIES - 1));
	end

endmodule

// File: rtl/hash_chained_fifo_result_cache.sv
// ----------------------------------------------------------------------------
// hash_chained_fifo_result_cache
// Routing result cache with per-bin linked chains and round-robin refill.
// ----------------------------------------------------------------------------
// Insert: read, unlink, head read, push and fix of the cursor entry.
// Lookup: head read and load, then a walk and a compare per entry; a hit
// relinks it and runs the insert steps. Each walk step is one registered
// read of the entry and link memories. Clear writes one entry and one bin
// head per cycle; the same pass runs after reset with busy high and no
// result. The receiver cannot stall: done is high for one cycle per item.
module hash_chained_fifo_result_cache (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [hcfrc_pkg::KIND_W-1:0]  kind,
	input  logic [hcfrc_pkg::BIN_W-1:0]   bin_index,
	input  logic [hcfrc_pkg::KEY_W-1:0]   search_key,
	input  logic [hcfrc_pkg::VAL_W-1:0]   new_reach,
	input  logic [hcfrc_pkg::VAL_W-1:0]   new_time,
	output logic                          done,
	output logic                          hit,
	output logic [hcfrc_pkg::VAL_W-1:0]   found_reach,
	output logic [hcfrc_pkg::VAL_W-1:0]   found_time,
	output logic [hcfrc_pkg::BIN_W-1:0]   slot_used
);
	import hcfrc_pkg::*;

	cmd_t    cmd;
	status_t status;

	hcfrc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	hcfrc_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.kind        (kind),
		.bin_index   (bin_index),
		.search_key  (search_key),
		.new_reach   (new_reach),
		.new_time    (new_time),
		.done        (done),
		.hit         (hit),
		.found_reach (found_reach),
		.found_time  (found_time),
		.slot_used   (slot_used)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("Accepted item did not raise busy.");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("Result strobe held for more than one cycle.");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy)) else $error("Result without a preceding item.");

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the chained result cache. Items are sent in
// bursts with random gaps; a scoreboard class keeps its own copy of the
// entry pool, the bin chains and the refill cursor, and checks every
// result against the expected hit flag, values and slot.
// ----------------------------------------------------------------------------
module tb;
	import hcfrc_pkg::*;

	typedef logic [LINK_W-1:0] link_t;

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] reach;
		logic [VAL_W-1:0] travel;
		logic [BIN_W-1:0] slot;
	} answer_t;

	class cache_scoreboard;
		logic [KEY_W-1:0] key_q   [NUM_ENTRIES];
		logic [BIN_W-1:0] bin_q   [NUM_ENTRIES];
		logic [VAL_W-1:0] reach_q [NUM_ENTRIES];
		logic [VAL_W-1:0] travel_q[NUM_ENTRIES];
		link_t            nxt     [NUM_ENTRIES];
		link_t            prv     [NUM_ENTRIES];
		link_t            head    [NUM_BINS];
		int               cursor;
		answer_t          awaited[$];
		int               errors;

		function new();
			errors = 0;
			wipe();
		endfunction

		function void wipe();
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				key_q[i] = '0;
				bin_q[i] = '0;
				reach_q[i] = '0;
				travel_q[i] = '0;
				prv[i] = (i == 0) ? LINK_NIL : link_t'(i - 1);
				nxt[i] = (i == NUM_ENTRIES - 1) ? LINK_NIL : link_t'(i + 1);
			end
			for (int b = 0; b < NUM_BINS; b++)
				head[b] = LINK_NIL;
			head[0] = '0;
			cursor = 0;
		endfunction

		function void unlink(int e);
			link_t p;
			link_t n;
			p = prv[e];
			n = nxt[e];
			if (p != LINK_NIL)
				nxt[p] = n;
			else
				head[bin_q[e]] = n;
			if (n != LINK_NIL)
				prv[n] = p;
			prv[e] = LINK_NIL;
			nxt[e] = LINK_NIL;
		endfunction

		function void push_head(int e, int b);
			link_t h;
			h = head[b];
			prv[e] = LINK_NIL;
			nxt[e] = h;
			if (h != LINK_NIL)
				prv[h] = link_t'(e);
			head[b] = link_t'(e);
		endfunction

		function int claim_cursor(int b, logic [KEY_W-1:0] k);
			int e;
			e = cursor;
			unlink(e);
			bin_q[e] = BIN_W'(b);
			key_q[e] = k;
			push_head(e, b);
			cursor = (e + 1) % NUM_ENTRIES;
			return e;
		endfunction

		function void note_item(logic [KIND_W-1:0] k, logic [BIN_W-1:0] b,
				logic [KEY_W-1:0] sk, logic [VAL_W-1:0] nr, logic [VAL_W-1:0] nt);
			answer_t a;
			link_t   e;
			int      steps;
			int      s;
			logic [VAL_W-1:0] r;
			logic [VAL_W-1:0] t;
			a = '0;
			if (k == KIND_CLEAR) begin
				wipe();
			end else if (k == KIND_INSERT && b < NUM_BINS) begin
				s = claim_cursor(b, sk);
				reach_q[s] = nr;
				travel_q[s] = nt;
				a.slot = BIN_W'(s);
			end else if (k == KIND_LOOKUP && b < NUM_BINS) begin
				e = head[b];
				steps = 0;
				while (e != LINK_NIL && steps < NUM_ENTRIES) begin
					if (key_q[e] == sk) begin
						r = reach_q[e];
						t = travel_q[e];
						unlink(e);
						key_q[e] = '0;
						bin_q[e] = '0;
						reach_q[e] = '0;
						travel_q[e] = '0;
						push_head(e, 0);
						s = claim_cursor(b, sk);
						reach_q[s] = r;
						travel_q[s] = t;
						a = '{1'b1, r, t, BIN_W'(s)};
						break;
					end
					e = nxt[e];
					steps++;
				end
			end
			awaited.push_back(a);
		endfunction

		function void check_result(answer_t got);
			answer_t want;
			if (awaited.size() == 0) begin
				$error("unexpected result");
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (got.hit !== want.hit) begin
				$error("hit: expected %0h, got %0h", want.hit, got.hit);
				errors++;
			end
			if (got.reach !== want.reach) begin
				$error("found_reach: expected %0h, got %0h", want.reach, got.reach);
				errors++;
			end
			if (got.travel !== want.travel) begin
				$error("found_time: expected %0h, got %0h", want.travel, got.travel);
				errors++;
			end
			if (got.slot !== want.slot) begin
				$error("slot_used: expected %0h, got %0h", want.slot, got.slot);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [KIND_W-1:0] kind;
	logic [BIN_W-1:0]  bin_index;
	logic [KEY_W-1:0]  search_key;
	logic [VAL_W-1:0]  new_reach;
	logic [VAL_W-1:0]  new_time;
	logic              done;
	logic              hit;
	logic [VAL_W-1:0]  found_reach;
	logic [VAL_W-1:0]  found_time;
	logic [BIN_W-1:0]  slot_used;

	cache_scoreboard sb = new();

	typedef struct packed {
		logic [BIN_W-1:0] b;
		logic [KEY_W-1:0] k;
	} stored_t;
	stored_t known[$];
	int      burst_left;

	hash_chained_fifo_result_cache dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("tb: done, errors");
		$finish;
	end

	always @(posedge clk)
		if (arst_n && done)
			sb.check_result('{hit, found_reach, found_time, slot_used});

	task automatic send_item(logic [KIND_W-1:0] k, logic [BIN_W-1:0] b,
			logic [KEY_W-1:0] sk, logic [VAL_W-1:0] nr, logic [VAL_W-1:0] nt);
		start <= 1'b1;
		kind <= k;
		bin_index <= b;
		search_key <= sk;
		new_reach <= nr;
		new_time <= nt;
		do @(posedge clk); while (busy);
		sb.note_item(k, b, sk, nr, nt);
		if (k == KIND_INSERT) begin
			known.push_back('{b, sk});
			if (known.size() > 48)
				void'(known.pop_front());
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
		end
	endtask

	function automatic logic [KEY_W-1:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	initial begin
		int      pick;
		stored_t s;
		start <= 1'b0;
		kind <= KIND_LOOKUP;
		bin_index <= '0;
		search_key <= '0;
		new_reach <= '0;
		new_time <= '0;
		burst_left = 0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(KIND_LOOKUP, 9'd0, 64'd0, '0, '0);
		send_item(KIND_INSERT, 9'd0, '1, 16'hFFFF, 16'h0000);
		send_item(KIND_INSERT, 9'd511, 64'd0, 16'h0000, 16'hFFFF);
		send_item(KIND_INSERT, 9'd511, 64'h8000_0000_0000_0001, 16'hA5A5, 16'h5A5A);
		send_item(KIND_LOOKUP, 9'd0, '1, '1, '1);
		send_item(KIND_LOOKUP, 9'd511, 64'd0, '0, '0);
		send_item(KIND_LOOKUP, 9'd511, 64'h8000_0000_0000_0001, '0, '0);
		send_item(KIND_LOOKUP, 9'd511, 64'h1234, '0, '0);
		send_item(KIND_LOOKUP, 9'd0, 64'd0, '0, '0);
		send_item(KIND_LOOKUP, 9'd300, '1, '0, '0);
		send_item(KIND_RSVD, 9'd511, '1, '1, '1);
		send_item(KIND_CLEAR, 9'd17, 64'd5, '0, '0);
		send_item(KIND_LOOKUP, 9'd0, 64'd0, '0, '0);
		send_item(KIND_LOOKUP, 9'd0, 64'd0, '0, '0);
		send_item(KIND_LOOKUP, 9'd7, 64'd0, '0, '0);
		send_item(KIND_LOOKUP, 9'd0, 64'hDEAD, '0, '0);

		for (int n = 0; n < 1500; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 50 && known.size() > 0) begin
				s = known[$urandom_range(0, known.size() - 1)];
				send_item(KIND_LOOKUP, s.b, s.k, VAL_W'(rand_key()), VAL_W'(rand_key()));
			end else if (pick < 80) begin
				send_item(KIND_INSERT,
					BIN_W'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15)),
					($urandom_range(0, 9) == 0) ? KEY_W'($urandom_range(0, 7)) : rand_key(),
					VAL_W'($urandom), VAL_W'($urandom));
			end else if (pick < 90) begin
				send_item(KIND_LOOKUP, BIN_W'($urandom_range(1, NUM_BINS - 1)), rand_key(),
					VAL_W'($urandom), VAL_W'($urandom));
			end else if (pick < 95) begin
				send_item(KIND_LOOKUP, 9'd0, ($urandom_range(0, 5) == 0) ? rand_key() : '0,
					VAL_W'($urandom), VAL_W'($urandom));
			end else if (pick < 97) begin
				send_item(KIND_CLEAR, BIN_W'($urandom), rand_key(),
					VAL_W'($urandom), VAL_W'($urandom));
			end else begin
				send_item(KIND_RSVD, BIN_W'($urandom), rand_key(),
					VAL_W'($urandom), VAL_W'($urandom));
			end
		end
		start <= 1'b0;

		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule

// File: hash_chained_fifo_result_cache.f
rtl/hcfrc_pkg.sv
rtl/hcfrc_ctrl.sv
rtl/hcfrc_dpath.sv
rtl/hash_chained_fifo_result_cache.sv
bench/tb.sv
